>>> sv/lccf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the load-cell calibrate/filter block.
// Used by every module of the block; depends on nothing else.
package lccf_pkg;

  // Sizes of the data path.
  localparam int SAMPLE_BITS  = 27;
  localparam int CFG_BITS     = 32;
  localparam int WIN_BITS     = 31;
  localparam int W_BITS       = 40;
  localparam int ACC_BITS     = 48;
  localparam int HISTORY_LEN  = 3;
  localparam int MIN_AGREE    = 2;
  localparam int AGREE_MAX    = (HISTORY_LEN > MIN_AGREE) ? HISTORY_LEN : MIN_AGREE;
  localparam int AGREE_BITS   = $clog2(AGREE_MAX + 1);

  // Gain is Q8.24 and weights are Q.8, so the product drops 16 fraction bits.
  localparam int GAIN_SHIFT   = 16;
  localparam int PROD_BITS    = SAMPLE_BITS + CFG_BITS;

  // One tenth as Q0.16, applied with a floor shift.
  localparam int TENTH_BITS   = 14;
  localparam int TENTH_SHIFT  = 16;
  localparam logic signed [TENTH_BITS-1:0] TENTH_Q16 = 14'sd6554;

  // Width used for saturating helpers.
  localparam int SAT_IN_BITS  = 64;

  // Queue between front and back.
  localparam int QUEUE_DEPTH  = 2;

  // Register reset values.
  localparam logic [CFG_BITS-1:0] GAIN_RESET   = 32'h0100_0000;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 31'd25600;

  localparam int CFG_ADDR_BITS = 2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_GAIN   = 2'd0,
    REG_ZERO   = 2'd1,
    REG_TARE   = 2'd2,
    REG_WINDOW = 2'd3
  } cfg_reg_t;

  // Calibration settings seen by the front end.
  typedef struct packed {
    logic [CFG_BITS-1:0] gain;
    logic [CFG_BITS-1:0] zero_offset;
    logic [CFG_BITS-1:0] tare_offset;
    logic [WIN_BITS-1:0] window;
  } cfg_t;

  // One classified sample handed from front to back.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [W_BITS-1:0]      weight;
    logic                   ok;
  } item_t;

  // Saturate a sign-extended value to the weight width.
  function automatic logic [W_BITS-1:0] sat_weight(input logic [SAT_IN_BITS-1:0] v);
    logic [W_BITS-1:0] res;
    if ((&v[SAT_IN_BITS-1:W_BITS-1]) || !(|v[SAT_IN_BITS-1:W_BITS-1])) begin
      res = v[W_BITS-1:0];
    end else if (v[SAT_IN_BITS-1]) begin
      res = {1'b1, {(W_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(W_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> sv/lccf_front.sv
`timescale 1ns / 1ps
// Front end: takes raw samples, calibrates them and grades them against history.
// Depends on lccf_pkg.
module lccf_front import lccf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SAMPLE_BITS-1:0] in_raw_sample,
  output logic                   q_push,
  input  logic                   q_full,
  output item_t                  q_item
);

  localparam int SHIFT_BITS = PROD_BITS - GAIN_SHIFT;
  localparam int SUM_BITS   = SHIFT_BITS + 2;
  localparam int DIFF_BITS  = W_BITS + 1;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_CMP} fstate_t;

  fstate_t                        state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]         raw_r;
  logic signed [PROD_BITS-1:0]    prod_r, prod_nxt;
  logic signed [W_BITS-1:0]       w_r, w_nxt;
  logic signed [W_BITS-1:0]       hist_r [HISTORY_LEN];
  logic signed [SHIFT_BITS-1:0]   shifted;
  logic signed [SUM_BITS-1:0]     sum;
  logic [HISTORY_LEN-1:0]         agree_vec;
  logic [AGREE_BITS-1:0]          agree_cnt;
  logic                           ok;

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_CMP) && !q_full;

  // Raw times gain, full precision.
  assign prod_nxt = $signed(raw_r) * $signed(cfg.gain);

  // Floor shift to Q.8, add both offsets, saturate to the weight width.
  assign shifted = prod_r[PROD_BITS-1:GAIN_SHIFT];
  assign sum = SUM_BITS'(shifted) + SUM_BITS'($signed(cfg.zero_offset))
             + SUM_BITS'($signed(cfg.tare_offset));
  assign w_nxt = $signed(sat_weight(SAT_IN_BITS'(sum)));

  // Count history entries within the window.
  always_comb begin
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        mag;
    agree_cnt = '0;
    for (int i = 0; i < HISTORY_LEN; i++) begin
      diff = DIFF_BITS'(w_r) - DIFF_BITS'(hist_r[i]);
      mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      agree_vec[i] = mag < {{(DIFF_BITS-WIN_BITS){1'b0}}, cfg.window};
      agree_cnt = agree_cnt + AGREE_BITS'(agree_vec[i]);
    end
  end

  assign ok = agree_cnt >= AGREE_BITS'(MIN_AGREE);

  assign q_item.raw    = raw_r;
  assign q_item.weight = w_r;
  assign q_item.ok     = ok;

  // Sequencer: multiply, sum, then compare and hand over.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_push) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUM;
      F_SUM:  state_nxt = F_CMP;
      F_CMP:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (q_push) begin
        for (int i = HISTORY_LEN - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= w_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      raw_r <= in_raw_sample;
    end
    if (state_r == F_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == F_SUM) begin
      w_r <= w_nxt;
    end
  end

endmodule

>>> sv/lccf_queue.sv
`timescale 1ns / 1ps
// Short register queue that decouples the front end from the filter back end.
// Depends on lccf_pkg.
module lccf_queue import lccf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t pop_item
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                do_push, do_pop;

  assign full     = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_item = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/lccf_back.sv
`timescale 1ns / 1ps
// Back end: runs the exponential filter on accepted samples and holds the result.
// Depends on lccf_pkg.
module lccf_back import lccf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [SAMPLE_BITS-1:0]   out_raw_echo,
  output logic signed [W_BITS-1:0] out_calibrated_weight,
  output logic                     out_accepted,
  output logic signed [W_BITS-1:0] out_held_weight,
  output logic signed [W_BITS-1:0] out_filtered_weight
);

  localparam int TPROD_BITS = ACC_BITS + TENTH_BITS;
  localparam int TEN_BITS   = TPROD_BITS - TENTH_SHIFT;
  localparam int ASUM_BITS  = ACC_BITS + 2;

  typedef enum logic [1:0] {B_IDLE, B_ACC, B_TENTH, B_OUT} bstate_t;

  bstate_t                      state_r, state_nxt;
  item_t                        item_r;
  logic signed [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic signed [TEN_BITS-1:0]   tenth_r;
  logic signed [W_BITS-1:0]     held_r, filt_r, filt_nxt;
  logic signed [TPROD_BITS-1:0] tprod;
  logic signed [ASUM_BITS-1:0]  asum;
  logic                         out_valid_r;
  logic                         out_free;

  assign out_empty = !out_valid_r;
  assign out_free  = !out_valid_r || out_pop;
  assign q_pop     = (state_r == B_IDLE) && q_valid;

  // Shared tenth multiplier; tenth_r takes tenth of the accumulator in B_TENTH, after each accumulate.
  assign tprod = acc_r * TENTH_Q16;

  // acc - tenth(acc) + weight, saturated to the accumulator width.
  assign asum = ASUM_BITS'(acc_r) - ASUM_BITS'(tenth_r) + ASUM_BITS'($signed(item_r.weight));
  always_comb begin
    if ((&asum[ASUM_BITS-1:ACC_BITS-1]) || !(|asum[ASUM_BITS-1:ACC_BITS-1])) begin
      acc_nxt = asum[ACC_BITS-1:0];
    end else if (asum[ASUM_BITS-1]) begin
      acc_nxt = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  // Filtered weight only moves for an accepted sample.
  assign filt_nxt = item_r.ok ? $signed(sat_weight(SAT_IN_BITS'(tenth_r))) : filt_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (q_valid) state_nxt = q_item.ok ? B_ACC : B_OUT;
      B_ACC:   state_nxt = B_TENTH;
      B_TENTH: state_nxt = B_OUT;
      B_OUT:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      acc_r       <= '0;
      tenth_r     <= '0;
      held_r      <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC) begin
        acc_r  <= acc_nxt;
        held_r <= $signed(item_r.weight);
      end
      if (state_r == B_TENTH) begin
        tenth_r <= tprod[TPROD_BITS-1:TENTH_SHIFT];
      end
      if (state_r == B_OUT && out_free) begin
        filt_r      <= filt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == B_OUT && out_free) begin
      out_raw_echo          <= item_r.raw;
      out_calibrated_weight <= $signed(item_r.weight);
      out_accepted          <= item_r.ok;
      out_held_weight       <= held_r;
      out_filtered_weight   <= filt_nxt;
    end
  end

endmodule

>>> sv/load_cell_calibrate_filter.sv
`timescale 1ns / 1ps
// Load-cell calibration and outlier-rejecting filter, top level.
// A sample passes the front multiply, sum and compare, the queue, then the back
// accumulate, tenth multiply and output; a rejected sample skips accumulate and tenth multiply.
// Front sequencer and back filter each hold one sample at a time; the queue decouples them.
// Reset (rst_n, synchronous) clears registers to defaults, history, accumulator and queue.
module load_cell_calibrate_filter import lccf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]      cfg_wdata,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [SAMPLE_BITS-1:0]   in_raw_sample,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [SAMPLE_BITS-1:0]   out_raw_echo,
  output logic signed [W_BITS-1:0] out_calibrated_weight,
  output logic                     out_accepted,
  output logic signed [W_BITS-1:0] out_held_weight,
  output logic signed [W_BITS-1:0] out_filtered_weight
);

  cfg_t  cfg_r;
  item_t f_item, q_item;
  logic  f_push, q_full, q_valid, q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain        <= GAIN_RESET;
      cfg_r.zero_offset <= '0;
      cfg_r.tare_offset <= '0;
      cfg_r.window      <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GAIN:   cfg_r.gain        <= cfg_wdata;
        REG_ZERO:   cfg_r.zero_offset <= cfg_wdata;
        REG_TARE:   cfg_r.tare_offset <= cfg_wdata;
        REG_WINDOW: cfg_r.window      <= cfg_wdata[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  lccf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_raw_sample (in_raw_sample),
    .q_push        (f_push),
    .q_full        (q_full),
    .q_item        (f_item)
  );

  lccf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  lccf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_raw_echo          (out_raw_echo),
    .out_calibrated_weight (out_calibrated_weight),
    .out_accepted          (out_accepted),
    .out_held_weight       (out_held_weight),
    .out_filtered_weight   (out_filtered_weight)
  );

endmodule

>>> tb/load_cell_calibrate_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for load_cell_calibrate_filter: directed and random samples
// are checked against an in-bench predictor of calibration, agreement and filtering.
// Depends on lccf_pkg and the load_cell_calibrate_filter RTL.
module load_cell_calibrate_filter_tb;
  import lccf_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 325;

  // One expected result of the block.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [W_BITS-1:0]      weight;
    logic                   ok;
    logic [W_BITS-1:0]      held;
    logic [W_BITS-1:0]      filtered;
  } reading_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_BITS-1:0]      cfg_wdata;
  logic                     in_push;
  logic                     in_full;
  logic [SAMPLE_BITS-1:0]   in_raw_sample;
  logic                     out_empty;
  logic                     out_pop;
  logic [SAMPLE_BITS-1:0]   out_raw_echo;
  logic signed [W_BITS-1:0] out_calibrated_weight;
  logic                     out_accepted;
  logic signed [W_BITS-1:0] out_held_weight;
  logic signed [W_BITS-1:0] out_filtered_weight;

  // Calibration settings and filter state as the predictor sees them.
  longint cal_gain;
  longint cal_zero;
  longint cal_tare;
  longint cal_window;
  longint weight_hist [HISTORY_LEN];
  longint filter_acc;
  longint held_w;
  longint filtered_w;

  reading_t pending_readings [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int n_sent;
  int n_checked;
  int n_accepted;
  int n_settings;
  int idle_cycles;

  load_cell_calibrate_filter u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_raw_sample         (in_raw_sample),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_raw_echo          (out_raw_echo),
    .out_calibrated_weight (out_calibrated_weight),
    .out_accepted          (out_accepted),
    .out_held_weight       (out_held_weight),
    .out_filtered_weight   (out_filtered_weight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Saturate a 64-bit value to a signed field of the given width.
  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Multiply by 6554/65536 with a floor shift.
  function automatic longint tenth_of(longint x);
    return (x * 6554) >>> TENTH_SHIFT;
  endfunction

  // Calibrate one sample, vote it against the history and advance the filter.
  function automatic reading_t predict_reading(logic [SAMPLE_BITS-1:0] raw);
    longint   sample;
    longint   w;
    longint   d;
    int       agree;
    int       i;
    reading_t r;
    sample = $signed(raw);
    w = (sample * cal_gain) >>> GAIN_SHIFT;
    w = clamp_signed(w + cal_zero + cal_tare, W_BITS);
    agree = 0;
    for (i = 0; i < HISTORY_LEN; i++) begin
      d = w - weight_hist[i];
      if (d < 0) d = -d;
      if (d < cal_window) agree++;
    end
    r.ok = (agree >= MIN_AGREE);
    if (r.ok) begin
      held_w = w;
      filter_acc = clamp_signed(filter_acc - tenth_of(filter_acc) + w, ACC_BITS);
      filtered_w = clamp_signed(tenth_of(filter_acc), W_BITS);
    end
    for (i = HISTORY_LEN - 1; i > 0; i--) weight_hist[i] = weight_hist[i-1];
    weight_hist[0] = w;
    r.raw      = raw;
    r.weight   = w[W_BITS-1:0];
    r.held     = held_w[W_BITS-1:0];
    r.filtered = filtered_w[W_BITS-1:0];
    return r;
  endfunction

  // Offer one sample after an optional random gap; predict it once the transfer happens.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      in_raw_sample <= SAMPLE_BITS'($urandom);
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (in_full);
    pending_readings.push_back(predict_reading(raw));
    n_sent++;
  endtask

  // Stop offering samples and wait until every expected result has been taken.
  task automatic settle_block();
    in_push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN:   cal_gain = longint'($signed(value));
      REG_ZERO:   cal_zero = longint'($signed(value));
      REG_TARE:   cal_tare = longint'($signed(value));
      REG_WINDOW: cal_window = longint'(value[WIN_BITS-1:0]);
      default:    ;
    endcase
  endtask

  // Write all four registers while the block is idle.
  task automatic load_calibration(logic [CFG_BITS-1:0] gain, logic [CFG_BITS-1:0] zero,
                                  logic [CFG_BITS-1:0] tare, logic [CFG_BITS-1:0] window);
    settle_block();
    write_register(REG_GAIN, gain);
    write_register(REG_ZERO, zero);
    write_register(REG_TARE, tare);
    write_register(REG_WINDOW, window);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stalls, and every transfer checked against the oldest expectation.
  always @(posedge clk) begin
    reading_t exp;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no expected reading (raw_echo %h)", out_raw_echo);
        mismatches++;
      end else begin
        exp = pending_readings.pop_front();
        n_checked++;
        if (out_accepted) n_accepted++;
        if (out_raw_echo !== exp.raw) begin
          $error("raw_echo: expected %h, got %h", exp.raw, out_raw_echo);
          mismatches++;
        end
        if (out_calibrated_weight !== exp.weight) begin
          $error("calibrated_weight: expected %0d, got %0d",
                 $signed(exp.weight), out_calibrated_weight);
          mismatches++;
        end
        if (out_accepted !== exp.ok) begin
          $error("accepted: expected %b, got %b", exp.ok, out_accepted);
          mismatches++;
        end
        if (out_held_weight !== exp.held) begin
          $error("held_weight: expected %0d, got %0d", $signed(exp.held), out_held_weight);
          mismatches++;
        end
        if (out_filtered_weight !== exp.filtered) begin
          $error("filtered_weight: expected %0d, got %0d",
                 $signed(exp.filtered), out_filtered_weight);
          mismatches++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("** load_cell_calibrate_filter: FAILED **");
      $finish;
    end
  end

  // Reset settings: field extremes, then a run that wins agreement back.
  task automatic test_reset_defaults();
    send_sample(27'h000_0000);
    send_sample(27'h000_0000);
    send_sample(27'h3FF_FFFF);
    send_sample(27'h400_0000);
    send_sample(27'h7FF_FFFF);
    send_sample(27'h000_0000);
    send_sample(27'h000_0001);
  endtask

  // Rejected samples still enter the history, so a repeated jump is taken on its third sample.
  task automatic test_outlier_recovery();
    repeat (3) send_sample(27'd1000000);
  endtask

  // Largest gains and offsets drive the weight into both saturation limits.
  task automatic test_saturation();
    load_calibration(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (4) send_sample(27'h3FF_FFFF);
    load_calibration(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    repeat (3) send_sample(27'h3FF_FFFF);
    repeat (2) send_sample(27'h400_0000);
  endtask

  // A zero window can never be met, so every sample is rejected.
  task automatic test_window_zero();
    load_calibration(GAIN_RESET, 32'd0, 32'd0, 32'd0);
    repeat (3) send_sample(27'h000_0000);
  endtask

  // A one-count gain makes the floor shift visible on small negative samples.
  task automatic test_floor_rounding();
    load_calibration(32'd1, 32'd0, 32'd0, 32'(WINDOW_RESET));
    send_sample(27'h7FF_FFFF);
    send_sample(27'h7FF_FFFF);
    send_sample(27'h000_0001);
  endtask

  task automatic random_calibration();
    logic [CFG_BITS-1:0] gain;
    logic [CFG_BITS-1:0] zero;
    logic [CFG_BITS-1:0] tare;
    logic [CFG_BITS-1:0] window;
    case ($urandom_range(3))
      0: gain = GAIN_RESET;
      1: gain = $urandom;
      2: begin
        gain = $urandom_range(32'h0040_0000, 32'h0400_0000);
        if ($urandom_range(1)) gain = -gain;
      end
      default: begin
        case ($urandom_range(3))
          0: gain = 32'h7FFF_FFFF;
          1: gain = 32'h8000_0000;
          2: gain = 32'd0;
          default: gain = 32'd1;
        endcase
      end
    endcase
    zero = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(20000)) - 10000);
    tare = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(20000)) - 10000);
    case ($urandom_range(9))
      0: window = 32'd0;
      1: window = 32'h7FFF_FFFF;
      2: window = $urandom;
      default: window = $urandom_range(1 << 17);
    endcase
    if ($urandom_range(3) == 0) window[CFG_BITS-1] = 1'b1;
    load_calibration(gain, zero, tare, window);
  endtask

  // Mostly runs of nearby samples that build agreement, plus lone and embedded outliers.
  task automatic send_random_run();
    logic [SAMPLE_BITS-1:0] base;
    int len;
    int span;
    int k;
    int noise;
    if ($urandom_range(99) < 15) begin
      send_sample(SAMPLE_BITS'($urandom));
    end else begin
      base = SAMPLE_BITS'($urandom);
      len = $urandom_range(3, 12);
      case ($urandom_range(3))
        0: span = 0;
        1: span = 3;
        2: span = 60;
        default: span = 1000;
      endcase
      for (k = 0; k < len; k++) begin
        noise = $urandom_range(2 * span) - span;
        if ($urandom_range(99) < 10) send_sample(SAMPLE_BITS'($urandom));
        else send_sample(base + SAMPLE_BITS'(noise));
      end
    end
  endtask

  task automatic run_pacing_phase(int send_pct, int stall_pct);
    int start;
    int next_cfg;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    start = n_sent;
    next_cfg = n_sent;
    while (n_sent - start < RANDOM_ITEMS) begin
      if (n_sent >= next_cfg) begin
        random_calibration();
        next_cfg = n_sent + $urandom_range(60, 140);
      end
      send_random_run();
    end
  endtask

  // Random traffic under each pacing pattern of the two handshakes.
  task automatic test_random_pacing();
    run_pacing_phase(0, 0);
    run_pacing_phase(84, 0);
    run_pacing_phase(0, 84);
    run_pacing_phase(32, 32);
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_GAIN;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_raw_sample = '0;
    out_pop = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    n_sent = 0;
    n_checked = 0;
    n_accepted = 0;
    n_settings = 0;
    idle_cycles = 0;
    cal_gain = longint'($signed(GAIN_RESET));
    cal_zero = 0;
    cal_tare = 0;
    cal_window = longint'(WINDOW_RESET);
    for (i = 0; i < HISTORY_LEN; i++) weight_hist[i] = 0;
    filter_acc = 0;
    held_w = 0;
    filtered_w = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_outlier_recovery();
    test_saturation();
    test_window_zero();
    test_floor_rounding();
    test_random_pacing();
    settle_block();

    $display("Checked %0d of %0d samples (%0d accepted) over %0d register settings,",
             n_checked, n_sent, n_accepted, n_settings);
    $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
    if (mismatches == 0) begin
      $display("** load_cell_calibrate_filter: PASSED **");
    end else begin
      $display("** load_cell_calibrate_filter: FAILED **");
    end
    $finish;
  end

endmodule
